/* src/power_output_board_supervisor_defines.svh */
// Assertion macros for the power output board supervisor.
// The first checks a property on every clock edge outside reset.
// The second checks that a condition holds in the cycle after a trigger.
`ifndef POWER_OUTPUT_BOARD_SUPERVISOR_DEFINES_SVH
`define POWER_OUTPUT_BOARD_SUPERVISOR_DEFINES_SVH
`ifndef SYNTHESIS
`define POBS_ASSERT(label, prop, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define POBS_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define POBS_ASSERT(label, prop, msg)
`define POBS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* src/pobs_pkg.sv */
package pobs_pkg;

	localparam int NUM_SLOTS   = 4;
	localparam int MAX_SLOTS   = 4;
	localparam int SLOT_IDX_W  = 2;
	localparam int ID_W        = 8;
	localparam int CNT_W       = 8;
	localparam int JOINTS      = 16;
	localparam int JMAP_W      = 32;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_IDX_W   = 3;

	localparam logic [2:0] REQ_RESTART = 3'd0;
	localparam logic [2:0] REQ_SCAN    = 3'd1;
	localparam logic [2:0] REQ_START   = 3'd2;
	localparam logic [2:0] REQ_STOP    = 3'd3;
	localparam logic [2:0] REQ_FAULT   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_BOARD_ID  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_ID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_JOINT_MAP = 3'd4;

	localparam logic [ID_W-1:0]   RST_BOARD_ID  = 8'd1;
	localparam logic [ID_W-1:0]   RST_EMPTY_ID  = 8'd255;
	localparam logic [CNT_W-1:0]  RST_STABLE    = 8'd3;
	localparam logic [CNT_W-1:0]  RST_CHANGE    = 8'd10;
	localparam logic [CNT_W-1:0]  CNT_MAX       = 8'd255;

	typedef struct packed {
		logic [ID_W-1:0]   board_id;
		logic [ID_W-1:0]   empty_id;
		logic [CNT_W-1:0]  stable_needed;
		logic [CNT_W-1:0]  change_limit;
		logic [JMAP_W-1:0] joint_map;
	} cfg_t;

	typedef struct packed {
		logic [2:0]                     req_type;
		logic [MAX_SLOTS-1:0][ID_W-1:0] slot_id;
		logic [MAX_SLOTS-1:0]           slot_unrecognized;
		logic                           overvoltage_flag;
		logic [JOINTS-1:0]              fuse_broken;
	} item_t;

	typedef struct packed {
		logic [JOINTS-1:0]      supply_mask;
		logic [JOINTS-1:0]      switch_word;
		logic                   output_on;
		logic                   check_armed;
		logic [MAX_SLOTS-1:0]   present_slots;
		logic [2:0]             error_bits;
		logic [2*MAX_SLOTS-1:0] slot_error_bits;
		logic                   detect_done;
	} result_t;

	// Two joint indices per slot, one byte per slot in the map.
	function automatic logic [JOINTS-1:0] joint_bits(logic [JMAP_W-1:0] jmap,
		logic [SLOT_IDX_W-1:0] slot);
		logic [JMAP_W-1:0] sh;
		logic [3:0]        lo;
		logic [3:0]        hi;
		sh = jmap >> {slot, 3'b000};
		lo = sh[3:0];
		hi = sh[7:4];
		return (JOINTS'(1) << lo) | (JOINTS'(1) << hi);
	endfunction

endpackage

/* src/power_output_board_supervisor.sv */
// Power output board supervisor.
// Events arrive on the s_t* stream, one transaction per event; s_tuser carries
// the event kind (restart detection, scan, start supply, stop supply, fault
// monitor) and s_tdata the slot IDs, read-failure bits, overvoltage and fuse
// bits. Every event yields exactly one status transaction on the m_t* stream,
// showing supply mask, switch word, power and check state, present slots,
// sticky error bits and whether detection is done, as they stand after it.
// The user must write registers over the cfg_* channel only while no event is
// in flight; the block itself does not enforce this. cfg_ready is always high.
// An event is held in an input register, evaluated against the state in
// combinational logic and written with the new state into an output register,
// which drives m_tvalid; one event is taken per cycle as long as m_tready
// stays high.
// When the receiver stalls, the output register holds its transaction and one
// more event waits in the input register; s_tready then drops until m_tready
// returns. Reset clears all state: detection runs, no slot present, supply
// off, no errors, and the registers take their default values.
`include "power_output_board_supervisor_defines.svh"

module power_output_board_supervisor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// slot_id_0, slot_id_1, slot_id_2, slot_id_3, slot_unrecognized,
	// overvoltage_flag, fuse_broken, zero fill
	input  logic [pobs_pkg::IN_TDATA_W-1:0]  s_tdata,
	// req_type
	input  logic [2:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// supply_mask, switch_word, output_on, check_armed, present_slots,
	// error_bits, slot_error_bits, detect_done, zero fill
	output logic [pobs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pobs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pobs_pkg::JMAP_W-1:0]      cfg_data
);

	pobs_pkg::cfg_t    cfg;
	pobs_pkg::item_t   in_item;
	pobs_pkg::item_t   item_s1;
	pobs_pkg::result_t result;
	pobs_pkg::result_t result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	assign in_item.req_type          = s_tuser;
	assign in_item.slot_id[0]        = s_tdata[7:0];
	assign in_item.slot_id[1]        = s_tdata[15:8];
	assign in_item.slot_id[2]        = s_tdata[23:16];
	assign in_item.slot_id[3]        = s_tdata[31:24];
	assign in_item.slot_unrecognized = s_tdata[35:32];
	assign in_item.overvoltage_flag  = s_tdata[36];
	assign in_item.fuse_broken       = s_tdata[52:37];

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, result_s2.detect_done, result_s2.slot_error_bits,
		result_s2.error_bits, result_s2.present_slots, result_s2.check_armed,
		result_s2.output_on, result_s2.switch_word, result_s2.supply_mask};

	pobs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pobs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	`POBS_ASSERT(a_power_check_pair, valid_s2 |-> (result_s2.output_on == result_s2.check_armed), "power/check differ")
	`POBS_ASSERT(a_mask_matches_power, valid_s2 |-> ((result_s2.supply_mask != '0) == result_s2.output_on), "mask/power differ")
	`POBS_ASSERT(a_switch_bits, valid_s2 |-> ((result_s2.switch_word & ~16'h1111) == 16'd0), "stray switch bit")
	`POBS_ASSERT_NEXT(a_stall_holds_item, (valid_s1 && valid_s2 && !m_tready), (valid_s1 && $stable(item_s1)), "event lost")

endmodule

/* src/pobs_cfg.sv */
module pobs_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pobs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pobs_pkg::JMAP_W-1:0]    cfg_data,
	output pobs_pkg::cfg_t                 cfg
);

	pobs_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.board_id      <= pobs_pkg::RST_BOARD_ID;
			cfg_q.empty_id      <= pobs_pkg::RST_EMPTY_ID;
			cfg_q.stable_needed <= pobs_pkg::RST_STABLE;
			cfg_q.change_limit  <= pobs_pkg::RST_CHANGE;
			cfg_q.joint_map     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pobs_pkg::CFG_BOARD_ID:  cfg_q.board_id      <= cfg_data[pobs_pkg::ID_W-1:0];
				pobs_pkg::CFG_EMPTY_ID:  cfg_q.empty_id      <= cfg_data[pobs_pkg::ID_W-1:0];
				pobs_pkg::CFG_STABLE:    cfg_q.stable_needed <= cfg_data[pobs_pkg::CNT_W-1:0];
				pobs_pkg::CFG_CHANGE:    cfg_q.change_limit  <= cfg_data[pobs_pkg::CNT_W-1:0];
				pobs_pkg::CFG_JOINT_MAP: cfg_q.joint_map     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* src/pobs_core.sv */
module pobs_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  pobs_pkg::cfg_t    cfg,
	input  pobs_pkg::item_t   item,
	output pobs_pkg::result_t result
);

	localparam int S  = pobs_pkg::MAX_SLOTS;
	localparam int IW = pobs_pkg::ID_W;
	localparam int CW = pobs_pkg::CNT_W;
	localparam int JW = pobs_pkg::JOINTS;

	logic [S-1:0][IW-1:0] prev_q, prev_n;
	logic [CW-1:0]        stable_q, stable_n;
	logic [CW-1:0]        change_q, change_n;
	logic                 detecting_q, detecting_n;
	logic [S-1:0]         present_q, present_n;
	logic                 check_q, check_n;
	logic                 power_q, power_n;
	logic [JW-1:0]        drive_q, drive_n;
	logic [JW-1:0]        switch_q, switch_n;
	logic [2:0]           err_q, err_n;
	logic [S-1:0][1:0]    serr_q, serr_n;

	logic [S-1:0][IW-1:0] now_ids;
	logic [S-1:0][IW-1:0] fin_ids;
	logic                 same;
	logic                 fin_en;
	logic                 halt;
	logic [CW-1:0]        stable_inc;
	logic [CW-1:0]        change_inc;
	logic [JW-1:0]        start_mask;
	logic [JW-1:0]        new_switch;

	always_comb begin
		prev_n      = prev_q;
		stable_n    = stable_q;
		change_n    = change_q;
		detecting_n = detecting_q;
		present_n   = present_q;
		check_n     = check_q;
		power_n     = power_q;
		drive_n     = drive_q;
		switch_n    = switch_q;
		err_n       = err_q;
		serr_n      = serr_q;
		fin_en      = 1'b0;
		halt        = 1'b0;
		new_switch  = '0;
		start_mask  = '0;

		same = 1'b1;
		for (int i = 0; i < S; i++) begin
			now_ids[i] = item.slot_unrecognized[i] ? cfg.empty_id : item.slot_id[i];
		end
		for (int i = 0; i < pobs_pkg::NUM_SLOTS; i++) begin
			if (now_ids[i] != prev_q[i]) begin
				same = 1'b0;
			end
		end
		fin_ids    = now_ids;
		stable_inc = (stable_q == pobs_pkg::CNT_MAX) ? stable_q : stable_q + CW'(1);
		change_inc = (change_q == pobs_pkg::CNT_MAX) ? change_q : change_q + CW'(1);
		for (int i = 0; i < pobs_pkg::NUM_SLOTS; i++) begin
			if (present_q[i]) begin
				start_mask = start_mask |
					pobs_pkg::joint_bits(cfg.joint_map, pobs_pkg::SLOT_IDX_W'(i));
			end
		end

		case (item.req_type)
			pobs_pkg::REQ_RESTART: begin
				for (int i = 0; i < S; i++) begin
					prev_n[i] = cfg.empty_id;
				end
				stable_n    = '0;
				change_n    = '0;
				detecting_n = 1'b1;
			end
			pobs_pkg::REQ_SCAN: begin
				if (detecting_q) begin
					if (same) begin
						stable_n = stable_inc;
						fin_en   = (stable_inc >= cfg.stable_needed);
					end else begin
						change_n = change_inc;
						stable_n = CW'(1);
						if (change_inc >= cfg.change_limit) begin
							// Timeout: every slot is treated as empty.
							for (int i = 0; i < S; i++) begin
								fin_ids[i] = cfg.empty_id;
							end
							err_n[1] = 1'b1;
							fin_en   = 1'b1;
						end else begin
							for (int i = 0; i < pobs_pkg::NUM_SLOTS; i++) begin
								prev_n[i] = now_ids[i];
							end
						end
					end
				end
			end
			pobs_pkg::REQ_START: begin
				if (start_mask != '0) begin
					drive_n = start_mask;
					power_n = 1'b1;
					check_n = 1'b1;
				end
			end
			pobs_pkg::REQ_STOP: begin
				halt = 1'b1;
			end
			pobs_pkg::REQ_FAULT: begin
				if (check_q) begin
					if (item.overvoltage_flag) begin
						halt     = 1'b1;
						err_n[2] = 1'b1;
					end
					for (int i = 0; i < pobs_pkg::NUM_SLOTS; i++) begin
						if (present_q[i] && ((item.fuse_broken &
							pobs_pkg::joint_bits(cfg.joint_map,
							pobs_pkg::SLOT_IDX_W'(i))) != '0)) begin
							halt         = 1'b1;
							err_n[0]     = 1'b1;
							serr_n[i][1] = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		if (halt) begin
			check_n = 1'b0;
			power_n = 1'b0;
			drive_n = '0;
		end

		if (fin_en) begin
			for (int i = 0; i < pobs_pkg::NUM_SLOTS; i++) begin
				if (fin_ids[i] != cfg.empty_id) begin
					if (fin_ids[i] == cfg.board_id) begin
						present_n[i]      = 1'b1;
						new_switch[4 * i] = 1'b1;
					end else begin
						err_n[0]  = 1'b1;
						serr_n[i] = 2'b01;
					end
				end
			end
			switch_n    = new_switch;
			detecting_n = 1'b0;
		end

		result.supply_mask     = drive_n;
		result.switch_word     = switch_n;
		result.output_on       = power_n;
		result.check_armed     = check_n;
		result.present_slots   = present_n;
		result.error_bits      = err_n;
		result.slot_error_bits = serr_n;
		result.detect_done     = !detecting_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < S; i++) begin
				prev_q[i] <= pobs_pkg::RST_EMPTY_ID;
			end
			stable_q    <= '0;
			change_q    <= '0;
			detecting_q <= 1'b1;
			present_q   <= '0;
			check_q     <= 1'b0;
			power_q     <= 1'b0;
			drive_q     <= '0;
			switch_q    <= '0;
			err_q       <= '0;
			serr_q      <= '0;
		end else if (step) begin
			prev_q      <= prev_n;
			stable_q    <= stable_n;
			change_q    <= change_n;
			detecting_q <= detecting_n;
			present_q   <= present_n;
			check_q     <= check_n;
			power_q     <= power_n;
			drive_q     <= drive_n;
			switch_q    <= switch_n;
			err_q       <= err_n;
			serr_q      <= serr_n;
		end
	end

endmodule
